[hdl/rlwq_pkg.sv]
// Package for the recursive lock with wait queue: field widths, status and
// operation codes, and the request and response structs shared by all files.
// No dependencies.
package rlwq_pkg;

    localparam int TID_W          = 5;
    localparam int STATUS_W       = 3;
    localparam int NUM_IDS        = 2 ** TID_W;
    localparam int THREADS_DEF    = 32;
    localparam int COUNT_BITS_DEF = 8;

    localparam logic OP_ACQUIRE = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_GRANTED         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NESTED          = 3'd1;
    localparam logic [STATUS_W-1:0] ST_WAIT            = 3'd2;
    localparam logic [STATUS_W-1:0] ST_STILL_HELD      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RELEASED        = 3'd4;
    localparam logic [STATUS_W-1:0] ST_ALREADY_WAITING = 3'd5;
    localparam logic [STATUS_W-1:0] ST_NOT_HOLDER      = 3'd6;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW        = 3'd7;

    typedef struct packed {
        logic             op;
        logic [TID_W-1:0] tid;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                wake_valid;
        logic [TID_W-1:0]    wake_thread;
    } t_rsp;

endpackage

[hdl/rlwq_core.sv]
// Lock state, nesting counter and FIFO of waiting threads for the recursive
// lock. Decides one request per cycle when i_advance is high. Uses rlwq_pkg.
module rlwq_core #(
    parameter int THREADS    = rlwq_pkg::THREADS_DEF,
    parameter int COUNT_BITS = rlwq_pkg::COUNT_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_advance,
    input  rlwq_pkg::t_req i_req,
    output rlwq_pkg::t_rsp o_rsp
);
    import rlwq_pkg::*;

    // Only ids below both THREADS and the id range can ever wait.
    localparam int QDEPTH = (THREADS < NUM_IDS) ? THREADS : NUM_IDS;
    localparam int QW     = $clog2(QDEPTH);
    localparam int FW     = $clog2(QDEPTH + 1);
    localparam logic [QW-1:0]         Q_LAST  = QW'(QDEPTH - 1);
    localparam logic [FW-1:0]         Q_FULL  = FW'(QDEPTH);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

    logic                  r_lock_free, n_lock_free;
    logic [TID_W-1:0]      r_holder, n_holder;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic [QW-1:0]         r_head, n_head;
    logic [QW-1:0]         r_tail, n_tail;
    logic [FW-1:0]         r_fill, n_fill;
    logic [QDEPTH-1:0]     r_mask, n_mask;
    logic [TID_W-1:0]      r_queue [QDEPTH];

    logic             owns;
    logic             tid_ok;
    logic [QW-1:0]    tid_idx;
    logic [TID_W-1:0] head_entry;
    logic             push;

    assign owns       = !r_lock_free && (r_holder == i_req.tid);
    assign tid_ok     = (int'(i_req.tid) < QDEPTH);
    assign tid_idx    = i_req.tid[QW-1:0];
    assign head_entry = r_queue[r_head];

    always_comb begin
        n_lock_free = r_lock_free;
        n_holder    = r_holder;
        n_count     = r_count;
        n_head      = r_head;
        n_tail      = r_tail;
        n_fill      = r_fill;
        n_mask      = r_mask;
        push        = 1'b0;
        o_rsp       = '0;
        if (i_req.op == OP_ACQUIRE) begin
            if (owns) begin
                if (r_count == CNT_MAX) begin
                    o_rsp.status = ST_OVERFLOW;
                end else begin
                    n_count      = r_count + CNT_ONE;
                    o_rsp.status = ST_NESTED;
                end
            end else if (r_lock_free) begin
                n_lock_free  = 1'b0;
                n_holder     = i_req.tid;
                n_count      = CNT_ONE;
                o_rsp.status = ST_GRANTED;
            end else if (!tid_ok || r_mask[tid_idx] || (r_fill == Q_FULL)) begin
                o_rsp.status = ST_ALREADY_WAITING;
            end else begin
                push            = 1'b1;
                n_tail          = (r_tail == Q_LAST) ? '0 : r_tail + QW'(1);
                n_fill          = r_fill + FW'(1);
                n_mask[tid_idx] = 1'b1;
                o_rsp.status    = ST_WAIT;
            end
        end else begin
            if (!owns) begin
                o_rsp.status = ST_NOT_HOLDER;
            end else if (r_count > CNT_ONE) begin
                n_count      = r_count - CNT_ONE;
                o_rsp.status = ST_STILL_HELD;
            end else begin
                n_lock_free  = 1'b1;
                n_holder     = '0;
                n_count      = '0;
                o_rsp.status = ST_RELEASED;
                if (r_fill != '0) begin
                    n_head                    = (r_head == Q_LAST) ? '0 : r_head + QW'(1);
                    n_fill                    = r_fill - FW'(1);
                    n_mask[head_entry[QW-1:0]] = 1'b0;
                    o_rsp.wake_valid          = 1'b1;
                    o_rsp.wake_thread         = head_entry;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lock_free <= 1'b1;
            r_holder    <= '0;
            r_count     <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_fill      <= '0;
            r_mask      <= '0;
        end else if (i_advance) begin
            r_lock_free <= n_lock_free;
            r_holder    <= n_holder;
            r_count     <= n_count;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_fill      <= n_fill;
            r_mask      <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance && push) begin
            r_queue[r_tail] <= i_req.tid;
        end
    end

    // Every queued thread has exactly one mask bit set.
    a_mask_matches_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_mask) == int'(r_fill))
        else $error("waiting mask population differs from queue fill");

    // A free lock has no nesting; a held lock has at least one level.
    a_count_vs_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lock_free == (r_count == '0))
        else $error("nest count inconsistent with lock state");

    // A push moves the tail by one slot.
    a_tail_moves_on_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && push) |=> (r_tail == (($past(r_tail) == Q_LAST) ? '0
                                             : $past(r_tail) + QW'(1))))
        else $error("queue tail did not advance on push");

endmodule

[hdl/recursive_lock_with_wait_queue.sv]
// Top level of the recursive lock with wait queue: request and result
// registers with their valid/ready handshakes around rlwq_core. Uses rlwq_pkg.
//
// Usage: each request item carries an operation (acquire or release) and the
// calling thread's id. Each request yields exactly one result item with a
// status, and on the final release a wake flag plus the id of the oldest
// waiter, which must then issue acquire again to compete for the lock.
// Requests enter a request register; when the result register is empty or
// is being emptied, the core decides the request and writes the result
// register in the same cycle, updating the lock state and queue.
// One item is accepted in every cycle as long as results are taken; the
// holder compare, mask lookup and queue pointer update are combinational
// in the core, which allows that rate. A new request is accepted while a
// finished result waits, so when the receiver stalls the block holds at
// most two items (one in each register) and then drops o_ready until a
// result is taken.
// Reset frees the lock, empties the queue and clears the waiting mask; no
// clearing pass is needed, so requests are accepted right after reset.
module recursive_lock_with_wait_queue #(
    parameter int THREADS    = rlwq_pkg::THREADS_DEF,
    parameter int COUNT_BITS = rlwq_pkg::COUNT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_op,
    input  logic [rlwq_pkg::TID_W-1:0]    i_thread_id,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [rlwq_pkg::STATUS_W-1:0] o_status,
    output logic                          o_wake_valid,
    output logic [rlwq_pkg::TID_W-1:0]    o_wake_thread
);
    import rlwq_pkg::*;

    logic r_in_valid;
    t_req r_in;
    logic r_out_valid;
    t_rsp r_out;
    t_rsp core_rsp;
    logic advance;
    logic accept;

    // A request is decided once the result slot is free or being freed.
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;
    assign accept  = i_valid && o_ready;

    rlwq_core #(
        .THREADS    (THREADS),
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_req     (r_in),
        .o_rsp     (core_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset; their valid flags guard them.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in.op  <= i_op;
            r_in.tid <= i_thread_id;
        end
        if (advance) begin
            r_out <= core_rsp;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out.status;
    assign o_wake_valid  = r_out.wake_valid;
    assign o_wake_thread = r_out.wake_thread;

    // A wake is only ever reported with a full release.
    a_wake_only_on_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_wake_valid) |-> (o_status == ST_RELEASED))
        else $error("wake reported without a release");

    // A pending request moves into the result register when the slot frees.
    a_request_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && (!r_out_valid || i_ready)) |=> r_out_valid)
        else $error("pending request not decided");

    // With no wake, the reported thread id is zero.
    a_wake_thread_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_wake_valid) |-> (o_wake_thread == '0))
        else $error("wake thread set without a wake");

endmodule
